// ===== hw/rtl/p1305_pkg.sv =====
// Shared types and constants for the Poly1305 tag engine.
// No dependencies; used by the interfaces, controller, datapath and top level.
package p1305_pkg;

  localparam int DIGIT_W    = 32;  // multiplier operand width
  localparam int NUM_DIGITS = 5;   // 32-bit digits of the 131-bit sum acc + block
  localparam int R_WORDS    = 4;   // 32-bit words of clamped r
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CNT_W      = 5;
  localparam int STEP_W     = 3;

  localparam logic [63:0] CLAMP_LOW  = 64'h0FFF_FFFC_0FFF_FFFF;
  localparam logic [63:0] CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R_LOW  = 2'd0,
    CFG_R_HIGH = 2'd1,
    CFG_S_LOW  = 2'd2,
    CFG_S_HIGH = 2'd3
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture padded block and last flag
    logic load_a;    // form acc + block, clear partial sum
    logic mul_en;    // issue one digit x r multiply
    logic acc_en;    // add registered partial products into running product
    logic fold1;     // first fold of the product mod 2^130-5
    logic fold2;     // second fold
    logic final_en;  // conditional subtract of p, write accumulator
    logic tag_en;    // form tag, clear accumulator
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ===== hw/rtl/p1305_if.sv =====
// Valid/ready channel interfaces for the Poly1305 tag engine.
// Depends on p1305_pkg for the byte count width.
interface p1305_in_if;
  logic                          valid;
  logic                          ready;
  logic [63:0]                   block_low;
  logic [63:0]                   block_high;
  logic [p1305_pkg::CNT_W-1:0]   byte_count;
  logic                          last_block;

  modport source (output valid, block_low, block_high, byte_count, last_block, input ready);
  modport sink   (input valid, block_low, block_high, byte_count, last_block, output ready);
endinterface

interface p1305_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_low;
  logic [63:0] tag_high;

  modport source (output valid, tag_low, tag_high, input ready);
  modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

// ===== hw/rtl/p1305_dp.sv =====
// Datapath of the Poly1305 tag engine: key registers, block padding,
// digit-serial multiply, reduction mod 2^130-5 and tag add. Uses p1305_pkg.
module p1305_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  p1305_pkg::cmd_t                   cmd,
  output p1305_pkg::status_t                status,
  input  logic                              cfg_we,
  input  logic [p1305_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [p1305_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [63:0]                       block_low,
  input  logic [63:0]                       block_high,
  input  logic [p1305_pkg::CNT_W-1:0]       byte_count,
  input  logic                              last_block,
  output logic [127:0]                      tag
);

  logic [63:0]  r_lo_r, r_hi_r, s_lo_r, s_hi_r;
  logic [127:0] r_clamp;
  logic [128:0] n_pad;
  logic [128:0] n_r;
  logic         last_r;
  logic [159:0] a_sh_r;
  logic [63:0]  pp_r [p1305_pkg::R_WORDS];
  logic [159:0] p_r, l_r;
  logic [160:0] sum_c;
  logic [124:0] hi_c;
  logic [131:0] v1_c, v2_c, red_r;
  logic [130:0] g_c;
  logic [129:0] acc_r;
  logic [127:0] tag_r;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_lo_r <= '0;
      r_hi_r <= '0;
      s_lo_r <= '0;
      s_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        p1305_pkg::CFG_R_LOW:  r_lo_r <= cfg_wdata;
        p1305_pkg::CFG_R_HIGH: r_hi_r <= cfg_wdata;
        p1305_pkg::CFG_S_LOW:  s_lo_r <= cfg_wdata;
        p1305_pkg::CFG_S_HIGH: s_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign r_clamp = {r_hi_r & p1305_pkg::CLAMP_HIGH, r_lo_r & p1305_pkg::CLAMP_LOW};

  // keep bytes below the count, 0x01 at the count; counts above 16 act as 16
  always_comb begin
    logic [p1305_pkg::CNT_W-1:0] cnt;
    logic [127:0]                blk;
    cnt = (byte_count > 5'd16) ? 5'd16 : byte_count;
    blk = {block_high, block_low};
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < cnt)
        n_pad[8*b +: 8] = blk[8*b +: 8];
      else if (5'(b) == cnt)
        n_pad[8*b +: 8] = 8'h01;
      else
        n_pad[8*b +: 8] = 8'h00;
    end
    n_pad[128] = (cnt == 5'd16);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      n_r    <= n_pad;
      last_r <= last_block;
    end
  end

  // operand shift register and four 32x32 multipliers
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_sh_r <= 160'(acc_r) + 160'(n_r);
    end else if (cmd.mul_en) begin
      a_sh_r <= a_sh_r >> p1305_pkg::DIGIT_W;
    end
    if (cmd.mul_en) begin
      for (int j = 0; j < p1305_pkg::R_WORDS; j++) begin
        pp_r[j] <= a_sh_r[31:0] * r_clamp[32*j +: 32];
      end
    end
  end

  // running product: low digits retire into l_r, upper part stays in p_r
  assign sum_c = 161'(p_r) + 161'({pp_r[2], pp_r[0]}) + 161'({pp_r[3], pp_r[1], 32'd0});

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      p_r <= '0;
    end else if (cmd.acc_en) begin
      p_r <= 160'(sum_c[160:32]);
      l_r <= {sum_c[31:0], l_r[159:32]};
    end
  end

  // 2^130 = 5 mod p: fold the high part back twice, then one subtract
  assign hi_c = {p_r[94:0], l_r[159:130]};
  assign v1_c = 132'(l_r[129:0]) + 132'(hi_c) + 132'({hi_c, 2'b00});
  assign v2_c = 132'(red_r[129:0]) + 132'({red_r[131:130], 2'b00}) + 132'(red_r[131:130]);
  assign g_c  = red_r[130:0] + 131'd5;

  always_ff @(posedge clk) begin
    if (cmd.fold1) begin
      red_r <= v1_c;
    end else if (cmd.fold2) begin
      red_r <= v2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.final_en) begin
      acc_r <= g_c[130] ? g_c[129:0] : red_r[129:0];
    end else if (cmd.tag_en) begin
      acc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag_en) begin
      tag_r <= acc_r[127:0] + {s_hi_r, s_lo_r};
    end
  end

  assign tag         = tag_r;
  assign status.last = last_r;

endmodule

// ===== hw/rtl/p1305_ctrl.sv =====
// Controller of the Poly1305 tag engine: sequencing state machine,
// multiply step counter and output valid. Uses p1305_pkg.
module p1305_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  p1305_pkg::status_t status,
  output p1305_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_FOLD1 = 7'b0001000,
    S_FOLD2 = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_TAG   = 7'b1000000
  } state_t;

  localparam logic [p1305_pkg::STEP_W-1:0] STEP_LAST = p1305_pkg::STEP_W'(p1305_pkg::NUM_DIGITS);

  state_t                        state_r, state_nxt;
  logic [p1305_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_a = 1'b1;
        step_nxt   = '0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        // products land in the cycle after issue
        cmd.mul_en = (step_r < STEP_LAST);
        cmd.acc_en = (step_r != '0);
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_FOLD1;
        end
      end
      S_FOLD1: begin
        cmd.fold1 = 1'b1;
        state_nxt = S_FOLD2;
      end
      S_FOLD2: begin
        cmd.fold2 = 1'b1;
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_en = 1'b1;
        state_nxt    = status.last ? S_TAG : S_IDLE;
      end
      S_TAG: begin
        if (!out_valid_r || out_ready) begin
          cmd.tag_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.tag_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOAD))
    else $error("accepted request did not start processing");
  a_tag_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tag_en |-> (!out_valid_r || out_ready))
    else $error("tag loaded over an untaken result");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (step_r <= STEP_LAST))
    else $error("multiply step counter overran");
  a_acc_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> $past(cmd.mul_en))
    else $error("partial sum taken without a product issued");
`endif

endmodule

// ===== hw/rtl/poly1305_mac_tag.sv =====
// Top level of the Poly1305 tag engine.
// Depends on p1305_pkg, p1305_if, p1305_ctrl and p1305_dp.
//
// Usage:
//   Key: write r_low, r_high, s_low, s_high (index 0..3) on the cfg_ port
//   while the engine is idle. r is clamped internally.
//   in_chan: one request per message block of 1 to 16 bytes, little-endian,
//   byte_count giving the valid bytes (above 16 acts as 16), last_block
//   flagging the end of the message.
//   out_chan: one request per message, carrying the 16-byte tag, issued
//   only after a block flagged last; the accumulator then clears itself.
// Sequence:
//   A block passes from acceptance through the load state, the multiply
//   steps (five 32-bit digits of acc + block against four 32x32
//   multipliers, plus one drain), the reduction states FOLD1, FOLD2 and
//   FINAL, and the idle state in which the next block is taken. The shared
//   multiplier array and the dependence on the previous accumulator keep a new block waiting until then.
//   A last block adds the TAG state, in which the tag is registered.
// Reset (rst_n low, synchronous): key registers and accumulator clear,
//   no tag is pending. Stall: the tag sits in an output register; further
//   blocks are still taken, and only the next tag waits for it to be read.
module poly1305_mac_tag (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [p1305_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [p1305_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  p1305_in_if.sink                          in_chan,
  p1305_out_if.source                       out_chan
);

  p1305_pkg::cmd_t    cmd;
  p1305_pkg::status_t status;
  logic [127:0]       tag;

  p1305_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  p1305_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .block_low  (in_chan.block_low),
    .block_high (in_chan.block_high),
    .byte_count (in_chan.byte_count),
    .last_block (in_chan.last_block),
    .tag        (tag)
  );

  // tag leaves little-endian: low word holds bytes 0..7
  assign out_chan.tag_low  = tag[63:0];
  assign out_chan.tag_high = tag[127:64];

endmodule
